// File: rtl/detx_pkg.sv
// shared types and constants for the dle/etx record deframer
`default_nettype none

package detx_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned RoleW = 2;

    localparam logic [ByteW-1:0] CH_ETX   = 8'h03;
    localparam logic [ByteW-1:0] CH_DLE   = 8'h10;
    localparam logic [ByteW-1:0] TYPE_POS = 8'h28;
    localparam logic [ByteW-1:0] TYPE_RCV = 8'h29;
    localparam logic [ByteW-1:0] TYPE_EPH = 8'h2a;

    // escape machine states
    typedef enum logic [1:0] {
        ESC_DATA      = 2'd0,
        ESC_AFTER_DLE = 2'd1,
        ESC_BETWEEN   = 2'd2
    } esc_state_t;

    // field phase doubles as the role code of the emitted byte
    typedef enum logic [RoleW-1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } phase_t;

    // decoded byte handed from the unstuffer to the classifier
    typedef struct packed {
        logic             emit;
        logic [ByteW-1:0] value;
    } dec_byte_t;

    // one result transaction
    typedef struct packed {
        logic [ByteW-1:0] byte_value;
        logic [RoleW-1:0] byte_role;
        logic [ByteW-1:0] payload_index;
        logic             type_unknown;
        logic             checksum_ok;
        logic             record_last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/detx_if.sv
// valid/ready channel interfaces for raw bytes and decoded results
`default_nettype none

interface detx_raw_if;
    logic                        valid;
    logic                        ready;
    logic [detx_pkg::ByteW-1:0]  raw_byte;

    modport source (output valid, output raw_byte, input ready);
    modport sink   (input valid, input raw_byte, output ready);
endinterface

interface detx_rec_if;
    logic                        valid;
    logic                        ready;
    logic [detx_pkg::ByteW-1:0]  byte_value;
    logic [detx_pkg::RoleW-1:0]  byte_role;
    logic [detx_pkg::ByteW-1:0]  payload_index;
    logic                        type_unknown;
    logic                        checksum_ok;
    logic                        record_last;

    modport source (
        output valid, output byte_value, output byte_role, output payload_index,
        output type_unknown, output checksum_ok, output record_last,
        input ready
    );
    modport sink (
        input valid, input byte_value, input byte_role, input payload_index,
        input type_unknown, input checksum_ok, input record_last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/detx_unstuff.sv
// dle escape machine: removes stuffing and drops bytes between frames
`default_nettype none

module detx_unstuff (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       consume,
    input  wire logic [detx_pkg::ByteW-1:0] raw_byte,
    output detx_pkg::dec_byte_t             dec
);
    import detx_pkg::*;

    esc_state_t state_reg;
    esc_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        if (consume)
        begin
            case (state_reg)
                ESC_AFTER_DLE:
                begin
                    state_next = (raw_byte == CH_ETX) ? ESC_BETWEEN : ESC_DATA;
                end
                ESC_BETWEEN:
                begin
                    if (raw_byte == CH_DLE)
                    begin
                        state_next = ESC_AFTER_DLE;
                    end
                end
                default:
                begin
                    state_next = (raw_byte == CH_DLE) ? ESC_AFTER_DLE : ESC_DATA;
                end
            endcase
        end
    end

    always_comb
    begin
        dec.value = raw_byte;
        case (state_reg)
            ESC_AFTER_DLE: dec.emit = consume && (raw_byte != CH_ETX);
            ESC_BETWEEN:   dec.emit = 1'b0;
            default:       dec.emit = consume && (raw_byte != CH_DLE);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ESC_DATA;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/detx_classify.sv
// field tracker: tags each decoded byte with its record role and checks the sum
`default_nettype none

module detx_classify (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire detx_pkg::dec_byte_t  dec,
    output detx_pkg::result_t         res
);
    import detx_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [ByteW-1:0] remain_reg;
    logic [ByteW-1:0] remain_next;
    logic [ByteW-1:0] pos_reg;
    logic [ByteW-1:0] pos_next;
    logic [ByteW-1:0] sum_reg;
    logic [ByteW-1:0] sum_next;
    logic             unk_reg;
    logic             unk_next;
    logic [ByteW-1:0] sum_add;
    logic [ByteW-1:0] remain_dec;

    assign sum_add    = sum_reg + dec.value;
    assign remain_dec = remain_reg - 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        unk_next    = unk_reg;
        res.byte_value    = dec.value;
        res.byte_role     = phase_reg;
        res.payload_index = '0;
        res.checksum_ok   = 1'b0;
        res.record_last   = 1'b0;
        case (phase_reg)
            PH_TYPE:
            begin
                sum_next   = dec.value;
                unk_next   = !((dec.value == TYPE_POS) || (dec.value == TYPE_RCV)
                               || (dec.value == TYPE_EPH));
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                sum_next    = sum_add;
                remain_next = dec.value;
                pos_next    = '0;
                phase_next  = (dec.value != '0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD:
            begin
                sum_next          = sum_add;
                res.payload_index = pos_reg;
                pos_next          = pos_reg + 8'd1;
                remain_next       = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next = PH_CHECK;
                end
            end
            default:
            begin
                res.checksum_ok = (sum_add == '0);
                res.record_last = 1'b1;
                sum_next        = '0;
                phase_next      = PH_TYPE;
            end
        endcase
        // flag reflects the type of the record this byte belongs to
        res.type_unknown = unk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            remain_reg <= '0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            unk_reg    <= 1'b0;
        end
        else if (dec.emit)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            unk_reg    <= unk_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dle_etx_record_deframer.sv
// Takes one raw byte per cycle, strips DLE stuffing, skips bytes between an
// ETX frame end and the next DLE, and tags each decoded byte as record type,
// length, payload byte (with index) or checksum, with checksum pass on the
// last byte of each record. One transaction is accepted every cycle when the
// output is not stalled; an accepted raw byte waits in the input register,
// and its decode lands in the result register, which presents the result.
// The escape and field state update together as each byte is consumed,
// which sets the one-byte-per-cycle rate. Escape bytes and bytes between
// frames give no result.
`default_nettype none

module dle_etx_record_deframer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    detx_raw_if.sink   byte_in,
    detx_rec_if.source rec_out
);
    import detx_pkg::*;

    logic             in_vld_reg;
    logic             in_vld_next;
    logic [ByteW-1:0] in_byte_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    result_t          out_data_reg;
    logic             advance;
    logic             consume;
    dec_byte_t        dec;
    result_t          res;

    // result register free or draining this cycle
    assign advance       = !out_vld_reg || rec_out.ready;
    assign consume       = in_vld_reg && advance;
    assign byte_in.ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next  = byte_in.ready ? byte_in.valid : in_vld_reg;
        out_vld_next = advance ? dec.emit : out_vld_reg;
    end

    detx_unstuff u_unstuff (
        .clk      (clk),
        .rst_n    (rst_n),
        .consume  (consume),
        .raw_byte (in_byte_reg),
        .dec      (dec)
    );

    detx_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .dec   (dec),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.raw_byte;
        end
        if (dec.emit)
        begin
            out_data_reg <= res;
        end
    end

    assign rec_out.valid         = out_vld_reg;
    assign rec_out.byte_value    = out_data_reg.byte_value;
    assign rec_out.byte_role     = out_data_reg.byte_role;
    assign rec_out.payload_index = out_data_reg.payload_index;
    assign rec_out.type_unknown  = out_data_reg.type_unknown;
    assign rec_out.checksum_ok   = out_data_reg.checksum_ok;
    assign rec_out.record_last   = out_data_reg.record_last;

    a_last_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        rec_out.valid |-> (rec_out.record_last == (rec_out.byte_role == PH_CHECK)))
        else $error("record_last does not match checksum role");

    a_index_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_out.valid && (rec_out.byte_role != PH_PAYLOAD)) |-> (rec_out.payload_index == '0))
        else $error("payload index set outside payload role");

    a_ok_on_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_out.valid && !rec_out.record_last) |-> !rec_out.checksum_ok)
        else $error("checksum pass outside checksum byte");

    a_stall_both_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_in.ready |-> (in_vld_reg && out_vld_reg))
        else $error("input stalled with a free register stage");

    a_emit_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        dec.emit |-> in_vld_reg)
        else $error("decoded byte emitted with no byte in input register");

endmodule

`default_nettype wire
